[sv/mdws_pkg.sv]
package mdws_pkg;

  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned SHARES_W = 19;
  localparam int unsigned USAGE_W  = 48;
  localparam int unsigned WINDOW_W = 24;

  localparam logic [SHARES_W-1:0] DEFAULT_WEIGHT = 19'd1024;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 24'd1000000;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_PICK   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NO_SLOT = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    mode_e               mode;
    logic [SLOT_W-1:0]   slot;
    logic [SHARES_W-1:0] shares;
    logic [USAGE_W-1:0]  usage_time;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] chosen_slot;
  } rsp_t;

  typedef logic [WINDOW_W-1:0] window_t;

endpackage

[sv/mdws_chan_if.sv]
interface mdws_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

[sv/mdws_ram.sv]
module mdws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mdws_eval.sv]
module mdws_eval #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      clr_i,
  input  logic                                      vld_i,
  input  logic [$clog2(SLOTS)-1:0]                  idx_i,
  input  logic [mdws_pkg::SHARES_W-1:0]             weight_i,
  input  logic [mdws_pkg::USAGE_W-1:0]              used_i,
  input  logic [mdws_pkg::SHARES_W+$clog2(SLOTS)-1:0] total_i,
  input  logic [mdws_pkg::WINDOW_W-1:0]             window_i,
  output logic                                      busy_o,
  output logic [$clog2(SLOTS)-1:0]                  lead_slot_o
);
  import mdws_pkg::*;

  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned TW  = SHARES_W + IW;
  localparam int unsigned HW  = USAGE_W / 2;
  localparam int unsigned MW  = HW + TW;
  localparam int unsigned PW  = SHARES_W + WINDOW_W;
  localparam int unsigned UTW = USAGE_W + TW;
  localparam int unsigned DW  = UTW + 1;

  // stage 1: partial products
  logic          v1_q;
  logic [IW-1:0] idx1_q;
  logic [MW-1:0] mh_q, ml_q;
  logic [PW-1:0] wp1_q;
  // stage 2: used * total
  logic           v2_q;
  logic [IW-1:0]  idx2_q;
  logic [UTW-1:0] ut_q;
  logic [PW-1:0]  wp2_q;
  // stage 3: scaled deficit
  logic                 v3_q;
  logic [IW-1:0]        idx3_q;
  logic signed [DW-1:0] d_q;
  // stage 4: running best
  logic                 found_q;
  logic signed [DW-1:0] best_q;
  logic [IW-1:0]        lead_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (clr_i) begin
        found_q <= 1'b0;
      end else if (v3_q && (!found_q || (d_q > best_q))) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx_i;
    mh_q   <= MW'(used_i[USAGE_W-1:HW]) * MW'(total_i);
    ml_q   <= MW'(used_i[HW-1:0]) * MW'(total_i);
    wp1_q  <= PW'(weight_i) * PW'(window_i);

    idx2_q <= idx1_q;
    ut_q   <= (UTW'(mh_q) << HW) + UTW'(ml_q);
    wp2_q  <= wp1_q;

    idx3_q <= idx2_q;
    d_q    <= $signed(DW'(wp2_q) - DW'(ut_q));

    // strictly greater: the lower slot keeps a tie
    if (v3_q && (!found_q || (d_q > best_q))) begin
      best_q      <= d_q;
      lead_slot_q <= idx3_q;
    end
  end

  assign busy_o      = v1_q || v2_q || v3_q;
  assign lead_slot_o = lead_slot_q;

endmodule

[sv/max_deficit_weighted_scheduler.sv]
// Channel   Direction  Payload
// req_chan  in         mode, slot, shares, usage_time
// rsp_chan  out        status, chosen_slot
// cfg_chan  in         window_us
//
// Add, remove and update are resolved in ST_IDLE and pass through ST_DONE to the
// output register. Pick walks the n allocated slots: the single read port of the weight and
// used-time memories is walked once to sum active weights and once to rank.
// Reset sets window_us to 1000000 and clears the slot count and active marks;
// the memories are not cleared, since only allocated slots are read.
// A finished result sits in the output register while the next request is
// taken; that request's result waits until the output register frees up.
module max_deficit_weighted_scheduler #(
  parameter int unsigned SLOTS = 16
) (
  input logic          clk_i,
  input logic          rst_ni,
  mdws_chan_if.sink    req_chan,
  mdws_chan_if.source  rsp_chan,
  mdws_chan_if.sink    cfg_chan
);
  import mdws_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = SHARES_W + IW;
  localparam int unsigned KW = 8;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SLOTS-1:0] act_q, act_d;
  window_t        window_q;
  logic [CW-1:0]  iss_q, iss_d;
  logic           rd_vld_q, rd_act_q;
  logic [TW-1:0]  total_q, total_d;
  rsp_t           res_q, res_d;
  logic           out_vld_q, out_vld_d;
  rsp_t           out_q, out_d;

  req_t                req;
  logic                req_acc;
  logic                full;
  logic                slot_ok;
  logic                issue;
  logic                ev_clr;
  logic                ev_busy;
  logic [IW-1:0]       lead_slot;
  logic                wt_we, used_we;
  logic [IW-1:0]       wr_addr;
  logic [SHARES_W-1:0] wt_wdata, wt_rdata;
  logic [USAGE_W-1:0]  used_wdata, used_rdata;

  assign req      = req_chan.data;
  assign req_chan.ready = (state_q == ST_IDLE);
  assign req_acc  = req_chan.valid && req_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign full    = (cnt_q == CW'(SLOTS));
  assign slot_ok = ({{(KW - SLOT_W){1'b0}}, req.slot} < KW'(cnt_q));
  assign issue   = ((state_q == ST_SUM) || (state_q == ST_EVAL)) && (iss_q != cnt_q);

  assign wr_addr    = (req.mode == MODE_ADD) ? cnt_q[IW-1:0] : IW'(req.slot);
  assign wt_we      = req_acc && (req.mode == MODE_ADD) && !full;
  assign wt_wdata   = (req.shares == '0) ? DEFAULT_WEIGHT : req.shares;
  assign used_we    = req_acc && (((req.mode == MODE_ADD) && !full) ||
                                  ((req.mode == MODE_UPDATE) && slot_ok));
  assign used_wdata = (req.mode == MODE_ADD) ? '0 : req.usage_time;
  assign ev_clr     = req_acc && (req.mode == MODE_PICK);

  mdws_ram #(.WIDTH(SHARES_W), .DEPTH(SLOTS)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .waddr_i (wr_addr),
    .wdata_i (wt_wdata),
    .raddr_i (iss_q[IW-1:0]),
    .rdata_o (wt_rdata)
  );

  mdws_ram #(.WIDTH(USAGE_W), .DEPTH(SLOTS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (wr_addr),
    .wdata_i (used_wdata),
    .raddr_i (iss_q[IW-1:0]),
    .rdata_o (used_rdata)
  );

  mdws_eval #(.SLOTS(SLOTS)) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (ev_clr),
    .vld_i       ((state_q == ST_EVAL) && rd_vld_q && rd_act_q),
    .idx_i       (iss_q[IW-1:0] - IW'(1)),
    .weight_i    (wt_rdata),
    .used_i      (used_rdata),
    .total_i     (total_q),
    .window_i    (window_q),
    .busy_o      (ev_busy),
    .lead_slot_o (lead_slot)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    iss_d     = iss_q;
    total_d   = total_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_chan.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          res_d.status      = STAT_OK;
          res_d.chosen_slot = '0;
          state_d           = ST_DONE;
          unique case (req.mode)
            MODE_ADD: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                res_d.chosen_slot       = SLOT_W'(cnt_q);
                act_d[cnt_q[IW-1:0]]    = 1'b1;
                cnt_d                   = cnt_q + CW'(1);
              end
            end
            MODE_REMOVE: begin
              if (slot_ok) begin
                act_d[IW'(req.slot)] = 1'b0;
              end else begin
                res_d.status = STAT_NO_SLOT;
              end
            end
            MODE_UPDATE: begin
              if (!slot_ok) begin
                res_d.status = STAT_NO_SLOT;
              end
            end
            MODE_PICK: begin
              if (cnt_q == '0) begin
                res_d.status = STAT_EMPTY;
              end else begin
                iss_d   = '0;
                total_d = '0;
                state_d = ST_SUM;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_SUM: begin
        if (issue) begin
          iss_d = iss_q + CW'(1);
        end
        if (rd_vld_q && rd_act_q) begin
          total_d = total_q + TW'(wt_rdata);
        end
        if (!issue && !rd_vld_q) begin
          if (total_q == '0) begin
            res_d.status      = STAT_EMPTY;
            res_d.chosen_slot = '0;
            state_d           = ST_DONE;
          end else begin
            iss_d   = '0;
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (issue) begin
          iss_d = iss_q + CW'(1);
        end
        if (!issue && !rd_vld_q && !ev_busy) begin
          res_d.status      = STAT_OK;
          res_d.chosen_slot = SLOT_W'(lead_slot);
          state_d           = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_vld_q || rsp_chan.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      act_q     <= '0;
      window_q  <= WINDOW_RESET;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      act_q     <= act_d;
      rd_vld_q  <= issue;
      out_vld_q <= out_vld_d;
      if (cfg_chan.valid && cfg_chan.ready) begin
        window_q <= cfg_chan.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q    <= iss_d;
    total_q  <= total_d;
    res_q    <= res_d;
    out_q    <= out_d;
    rd_act_q <= act_q[iss_q[IW-1:0]];
  end

  assign rsp_chan.valid = out_vld_q;
  assign rsp_chan.data  = out_q;

endmodule

[sv/mdws_checker.sv]
module mdws_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input mdws_pkg::rsp_t rsp_data_i
);
  import mdws_pkg::*;

  logic       req_acc, rsp_acc;
  logic [1:0] pend_q, pend_d;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (req_acc && !rsp_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!req_acc && rsp_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("response changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_acc |-> pend_q != 2'd0)
    else $error("response without a pending request");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 2'd2)
    else $error("more than two requests in flight");

  a_err_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == STAT_FULL || rsp_data_i.status == STAT_NO_SLOT ||
                    rsp_data_i.status == STAT_EMPTY) |-> rsp_data_i.chosen_slot == '0)
    else $error("error response carries a slot");

endmodule

bind max_deficit_weighted_scheduler mdws_checker u_mdws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_chan.valid),
  .req_ready_i (req_chan.ready),
  .rsp_valid_i (rsp_chan.valid),
  .rsp_ready_i (rsp_chan.ready),
  .rsp_data_i  (rsp_chan.data)
);

[bench/mdws_grant_checker.sv]
`timescale 1ns / 100ps

module mdws_grant_checker
  import mdws_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  window_t     cfg_data_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o
);

  // Shadow copy of the client table
  window_t             window_us;
  logic [SHARES_W-1:0] share_of   [NUM_SLOTS];
  logic [USAGE_W-1:0]  used_of    [NUM_SLOTS];
  logic                live_of    [NUM_SLOTS];
  int unsigned         slots_taken;

  rsp_t grant_queue [$];
  rsp_t oldest_grant;

  function automatic rsp_t schedule_request(req_t r);
    rsp_t                res;
    logic [63:0]         total_share;
    logic [127:0]        entitled;
    logic [127:0]        consumed;
    logic signed [127:0] deficit;
    logic signed [127:0] lead_deficit;
    bit                  have_best;
    res.status      = STAT_OK;
    res.chosen_slot = '0;
    case (r.mode)
      MODE_ADD: begin
        if (slots_taken >= NUM_SLOTS) begin
          res.status = STAT_FULL;
        end else begin
          share_of[slots_taken] = (r.shares == '0) ? DEFAULT_WEIGHT : r.shares;
          used_of[slots_taken]  = '0;
          live_of[slots_taken]  = 1'b1;
          res.chosen_slot       = slots_taken[SLOT_W-1:0];
          slots_taken++;
        end
      end
      MODE_REMOVE, MODE_UPDATE: begin
        if (r.slot >= slots_taken) begin
          res.status = STAT_NO_SLOT;
        end else if (r.mode == MODE_REMOVE) begin
          live_of[r.slot] = 1'b0;
        end else begin
          used_of[r.slot] = r.usage_time;
        end
      end
      default: begin
        total_share = '0;
        for (int i = 0; i < slots_taken; i++)
          if (live_of[i]) total_share += share_of[i];
        if (total_share == '0) begin
          res.status = STAT_EMPTY;
        end else begin
          have_best    = 1'b0;
          lead_deficit = '0;
          // Rank by weight * window - used * total, scaled to avoid the division
          for (int i = 0; i < slots_taken; i++) begin
            if (live_of[i]) begin
              entitled = 128'(share_of[i]) * 128'(window_us);
              consumed = 128'(used_of[i]) * 128'(total_share);
              deficit  = $signed(entitled - consumed);
              if (!have_best || deficit > lead_deficit) begin
                lead_deficit    = deficit;
                res.chosen_slot = i[SLOT_W-1:0];
                have_best       = 1'b1;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_us   = WINDOW_RESET;
      slots_taken = 0;
      for (int i = 0; i < NUM_SLOTS; i++) live_of[i] = 1'b0;
      grant_queue.delete();
      errors_o      = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) window_us = cfg_data_i;
      if (rsp_valid_i && rsp_ready_i) begin
        if (grant_queue.size() == 0) begin
          $error("unexpected result: status %0d, chosen_slot %0d",
                 rsp_data_i.status, rsp_data_i.chosen_slot);
          errors_o++;
        end else begin
          oldest_grant = grant_queue.pop_front();
          if (rsp_data_i.status !== oldest_grant.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   oldest_grant.status, rsp_data_i.status);
            errors_o++;
          end
          if (rsp_data_i.chosen_slot !== oldest_grant.chosen_slot) begin
            $error("chosen_slot mismatch: expected %0d, actual %0d",
                   oldest_grant.chosen_slot, rsp_data_i.chosen_slot);
            errors_o++;
          end
        end
      end
      if (req_valid_i && req_ready_i) grant_queue.push_back(schedule_request(req_data_i));
      outstanding_o = grant_queue.size();
    end
  end

endmodule

[bench/max_deficit_weighted_scheduler_tb.sv]
`timescale 1ns / 100ps

module max_deficit_weighted_scheduler_tb;
  import mdws_pkg::*;

  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS   = 250;

  logic clk_i;
  logic rst_ni;

  mdws_chan_if #(.T(req_t))    req_if ();
  mdws_chan_if #(.T(rsp_t))    rsp_if ();
  mdws_chan_if #(.T(window_t)) cfg_if ();

  int unsigned       mismatches;
  int unsigned       pending;
  window_t           window_now;
  logic [USAGE_W-1:0] last_usage;
  bit                req_steady;
  bit                rsp_steady;

  max_deficit_weighted_scheduler u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_chan (req_if),
    .rsp_chan (rsp_if),
    .cfg_chan (cfg_if)
  );

  mdws_grant_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_data_i    (req_if.data),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_data_i    (rsp_if.data),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_data_i    (cfg_if.data),
    .errors_o      (mismatches),
    .outstanding_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1500000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic req_t request_of(mode_e m, int unsigned s, int unsigned w,
                                      logic [USAGE_W-1:0] u);
    req_t r;
    r.mode       = m;
    r.slot       = s[SLOT_W-1:0];
    r.shares     = w[SHARES_W-1:0];
    r.usage_time = u;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    int unsigned share_roll;
    int unsigned usage_roll;
    roll       = $urandom_range(0, 999);
    share_roll = $urandom_range(0, 99);
    usage_roll = $urandom_range(0, 99);
    if (roll < 30)       r.mode = MODE_ADD;
    else if (roll < 35)  r.mode = MODE_REMOVE;
    else if (roll < 520) r.mode = MODE_UPDATE;
    else                 r.mode = MODE_PICK;
    r.slot = SLOT_W'($urandom_range(0, 15));
    if (share_roll < 25)      r.shares = '0;
    else if (share_roll < 32) r.shares = SHARES_W'(1);
    else if (share_roll < 40) r.shares = DEFAULT_WEIGHT;
    else if (share_roll < 45) r.shares = SHARES_W'(262144);
    else                      r.shares = SHARES_W'($urandom_range(1, 262144));
    // Keep most usages near the entitlement scale so the ranking stays contested
    if (usage_roll < 10)      r.usage_time = '0;
    else if (usage_roll < 22) r.usage_time = USAGE_W'({$urandom, $urandom});
    else if (usage_roll < 26) r.usage_time = '1;
    else if (usage_roll < 36) r.usage_time = last_usage;
    else r.usage_time = USAGE_W'($urandom_range(0, int'(window_now) + 3));
    last_usage = r.usage_time;
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = req_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input window_t w);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    window_now = w;
  endtask

  // Result side: stall a random number of cycles before each result
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rsp_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  initial begin
    window_t phase_window [RANDOM_PHASES];
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    rsp_if.ready <= 1'b0;
    window_now   = WINDOW_RESET;
    last_usage   = '0;
    req_steady   = 1'b0;
    rsp_steady   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, unallocated slots, default weight, weight extremes, ties,
    // removal of an inactive slot and usage written to an inactive slot
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_REMOVE, 0,  0,      '0));
    send_request(request_of(MODE_UPDATE, 15, 0,      '1));
    send_request(request_of(MODE_ADD,    0,  0,      '0));
    send_request(request_of(MODE_ADD,    0,  262144, '0));
    send_request(request_of(MODE_ADD,    0,  1,      '0));
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_UPDATE, 1,  0,      '1));
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_ADD,    0,  1024,   '0));
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_REMOVE, 0,  0,      '0));
    send_request(request_of(MODE_REMOVE, 0,  0,      '0));
    send_request(request_of(MODE_UPDATE, 0,  0,      48'd5));
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_UPDATE, 4,  0,      48'd7));
    send_request(request_of(MODE_UPDATE, 3,  0,      48'h8000_0000_0000));
    send_request(request_of(MODE_UPDATE, 2,  0,      '0));
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_REMOVE, 1,  0,      '0));
    send_request(request_of(MODE_REMOVE, 2,  0,      '0));
    send_request(request_of(MODE_REMOVE, 3,  0,      '0));
    send_request(request_of(MODE_PICK,   0,  0,      '0));
    send_request(request_of(MODE_REMOVE, 15, 0,      '0));

    phase_window[0] = '0;
    phase_window[1] = '1;
    phase_window[2] = window_t'(1);
    phase_window[3] = window_t'($urandom_range(1, 16777215));
    phase_window[4] = WINDOW_RESET;
    phase_window[5] = window_t'($urandom_range(1, 4095));
    phase_window[6] = '1;
    phase_window[7] = window_t'($urandom_range(1, 16777215));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_window(phase_window[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Redraw whether each side runs without gaps for the next stretch
        if (n % 50 == 0) begin
          req_steady = ($urandom_range(0, 3) == 0);
          rsp_steady = ($urandom_range(0, 3) == 0);
        end
        send_request(random_request());
      end
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
